// File: sv/itacc_pkg.sv
// Shared types and constants for the inertia tensor accumulator.
// Holds the controller states, the command and status structs and axis codes.
// No dependencies; every other file imports this package.
package itacc_pkg;

  // Right shift applied to every mass-weighted product before accumulation.
  localparam int unsigned PROD_SHIFT = 16;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Z = 2'd2;

  // Axis codes, used to pick operands and accumulator slots.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Accumulator file: three diagonal sums, then the three cross sums.
  localparam int unsigned ACC_COUNT  = 6;
  localparam logic [2:0]  CROSS_BASE = 3'd3;

  // One state per micro-step of the per-particle sequence.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MD_X,
    ST_MD_Y,
    ST_MD_Z,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_XY,
    ST_XZ,
    ST_YZ,
    ST_TXX,
    ST_TYY,
    ST_TZZ,
    ST_ADZZ,
    ST_EMIT
  } itacc_state_t;

  // Where the shared multiplier's product is written.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_TO_MD,
    MUL_TO_SQ,
    MUL_TO_TERM
  } itacc_mul_dst_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic           capture;    // load a new particle
    itacc_mul_dst_t mul_dst;    // product destination
    logic           mul_mass;   // operand A is the mass instead of a weighted delta
    logic [1:0]     mul_a;      // axis of the weighted delta used as operand A
    logic [1:0]     mul_b;      // axis of the delta used as operand B
    logic [1:0]     mul_slot;   // destination slot for MD and SQ writes
    logic           sq_sum_en;  // load the term from the sum of two squares
    logic [1:0]     sq_skip;    // axis whose square is left out of that sum
    logic           acc_en;     // add the term into an accumulator
    logic           acc_cross;  // subtract into a cross sum instead of a diagonal
    logic [1:0]     acc_slot;   // accumulator slot within its group
    logic           emit;       // move the sums to the output and clear them
  } itacc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_last;  // the particle in work closes its set
    logic out_full;   // the output register cannot take a result this cycle
  } itacc_status_t;

endpackage

// File: sv/itacc_ctrl.sv
// Sequencer for the inertia tensor accumulator.
// Steps the datapath through the products and accumulations of one particle.
// Depends on itacc_pkg.
module itacc_ctrl import itacc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  itacc_status_t status,
  output itacc_cmd_t    cmd
);

  itacc_state_t state_r;
  itacc_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a fixed walk through the steps, with a wait for the output.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MD_X;
      end
      ST_MD_X: state_nxt = ST_MD_Y;
      ST_MD_Y: state_nxt = ST_MD_Z;
      ST_MD_Z: state_nxt = ST_SQ_X;
      ST_SQ_X: state_nxt = ST_SQ_Y;
      ST_SQ_Y: state_nxt = ST_SQ_Z;
      ST_SQ_Z: state_nxt = ST_XY;
      ST_XY:   state_nxt = ST_XZ;
      ST_XZ:   state_nxt = ST_YZ;
      ST_YZ:   state_nxt = ST_TXX;
      ST_TXX:  state_nxt = ST_TYY;
      ST_TYY:  state_nxt = ST_TZZ;
      ST_TZZ:  state_nxt = ST_ADZZ;
      ST_ADZZ: begin
        state_nxt = status.item_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!status.out_full) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command decode for each step.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_MD_X: begin
        cmd.mul_dst  = MUL_TO_MD;
        cmd.mul_mass = 1'b1;
        cmd.mul_b    = AXIS_X;
        cmd.mul_slot = AXIS_X;
      end
      ST_MD_Y: begin
        cmd.mul_dst  = MUL_TO_MD;
        cmd.mul_mass = 1'b1;
        cmd.mul_b    = AXIS_Y;
        cmd.mul_slot = AXIS_Y;
      end
      ST_MD_Z: begin
        cmd.mul_dst  = MUL_TO_MD;
        cmd.mul_mass = 1'b1;
        cmd.mul_b    = AXIS_Z;
        cmd.mul_slot = AXIS_Z;
      end
      ST_SQ_X: begin
        cmd.mul_dst  = MUL_TO_SQ;
        cmd.mul_a    = AXIS_X;
        cmd.mul_b    = AXIS_X;
        cmd.mul_slot = AXIS_X;
      end
      ST_SQ_Y: begin
        cmd.mul_dst  = MUL_TO_SQ;
        cmd.mul_a    = AXIS_Y;
        cmd.mul_b    = AXIS_Y;
        cmd.mul_slot = AXIS_Y;
      end
      ST_SQ_Z: begin
        cmd.mul_dst  = MUL_TO_SQ;
        cmd.mul_a    = AXIS_Z;
        cmd.mul_b    = AXIS_Z;
        cmd.mul_slot = AXIS_Z;
      end
      ST_XY: begin
        cmd.mul_dst = MUL_TO_TERM;
        cmd.mul_a   = AXIS_X;
        cmd.mul_b   = AXIS_Y;
      end
      ST_XZ: begin
        cmd.mul_dst   = MUL_TO_TERM;
        cmd.mul_a     = AXIS_X;
        cmd.mul_b     = AXIS_Z;
        cmd.acc_en    = 1'b1;
        cmd.acc_cross = 1'b1;
        cmd.acc_slot  = AXIS_X;
      end
      ST_YZ: begin
        cmd.mul_dst   = MUL_TO_TERM;
        cmd.mul_a     = AXIS_Y;
        cmd.mul_b     = AXIS_Z;
        cmd.acc_en    = 1'b1;
        cmd.acc_cross = 1'b1;
        cmd.acc_slot  = AXIS_Y;
      end
      ST_TXX: begin
        cmd.sq_sum_en = 1'b1;
        cmd.sq_skip   = AXIS_X;
        cmd.acc_en    = 1'b1;
        cmd.acc_cross = 1'b1;
        cmd.acc_slot  = AXIS_Z;
      end
      ST_TYY: begin
        cmd.sq_sum_en = 1'b1;
        cmd.sq_skip   = AXIS_Y;
        cmd.acc_en    = 1'b1;
        cmd.acc_slot  = AXIS_X;
      end
      ST_TZZ: begin
        cmd.sq_sum_en = 1'b1;
        cmd.sq_skip   = AXIS_Z;
        cmd.acc_en    = 1'b1;
        cmd.acc_slot  = AXIS_Y;
      end
      ST_ADZZ: begin
        cmd.acc_en   = 1'b1;
        cmd.acc_slot = AXIS_Z;
      end
      ST_EMIT: begin
        cmd.emit = !status.out_full;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: sv/itacc_dp.sv
// Datapath of the inertia tensor accumulator: center registers, deltas,
// one shared multiplier, a saturating accumulator file and the output register.
// Depends on itacc_pkg.
module itacc_dp import itacc_pkg::*; #(
  parameter int unsigned POSITION_BITS = 20,
  parameter int unsigned MASS_BITS     = 18,
  parameter int unsigned ACC_BITS      = 56
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  itacc_cmd_t                      cmd,
  output itacc_status_t                   status,
  input  logic                            cfg_we,
  input  logic [CFG_INDEX_W-1:0]          cfg_index,
  input  logic [POSITION_BITS-1:0]        cfg_data,
  input  logic [MASS_BITS-1:0]            in_mass,
  input  logic signed [POSITION_BITS-1:0] in_pos_x,
  input  logic signed [POSITION_BITS-1:0] in_pos_y,
  input  logic signed [POSITION_BITS-1:0] in_pos_z,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ACC_BITS-2:0]             out_ixx,
  output logic [ACC_BITS-2:0]             out_iyy,
  output logic [ACC_BITS-2:0]             out_izz,
  output logic signed [ACC_BITS-1:0]      out_ixy,
  output logic signed [ACC_BITS-1:0]      out_ixz,
  output logic signed [ACC_BITS-1:0]      out_iyz,
  output logic                            out_saturated
);

  // Delta, weighted delta, product, term and accumulate widths.
  localparam int unsigned D_W  = POSITION_BITS + 1;
  localparam int unsigned MD_W = MASS_BITS + POSITION_BITS + 2;
  localparam int unsigned P_W  = MD_W + D_W;
  localparam int unsigned T_W  = P_W + 1 - PROD_SHIFT;
  localparam int unsigned S_W  = (ACC_BITS > T_W) ? ACC_BITS + 2 : T_W + 2;

  localparam logic signed [S_W-1:0] ACC_HI =
    {{(S_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [S_W-1:0] ACC_LO = ~ACC_HI;

  logic signed [POSITION_BITS-1:0] center_r [3];
  logic [MASS_BITS-1:0]            mass_r;
  logic signed [D_W-1:0]           d_r [3];
  logic                            last_r;
  logic signed [MD_W-1:0]          md_r [3];
  logic signed [P_W-1:0]           sq_r [3];
  logic signed [T_W-1:0]           term_r;
  logic signed [ACC_BITS-1:0]      acc_r [ACC_COUNT];
  logic                            ovf_r;

  logic                            out_valid_r;
  logic [ACC_BITS-2:0]             out_ixx_r;
  logic [ACC_BITS-2:0]             out_iyy_r;
  logic [ACC_BITS-2:0]             out_izz_r;
  logic signed [ACC_BITS-1:0]      out_ixy_r;
  logic signed [ACC_BITS-1:0]      out_ixz_r;
  logic signed [ACC_BITS-1:0]      out_iyz_r;
  logic                            out_sat_r;

  logic signed [MD_W-1:0]          mul_a;
  logic signed [D_W-1:0]           mul_b;
  logic signed [P_W-1:0]           prod;
  logic signed [P_W-1:0]           sq_a;
  logic signed [P_W-1:0]           sq_b;
  logic signed [P_W:0]             sq_sum;
  logic [2:0]                      acc_idx;
  logic signed [S_W-1:0]           acc_ext;
  logic signed [S_W-1:0]           term_ext;
  logic signed [S_W-1:0]           acc_sum;
  logic signed [ACC_BITS-1:0]      acc_nxt;
  logic                            acc_clip;

  // Center registers, written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: center_r[0] <= cfg_data;
        REG_CENTER_Y: center_r[1] <= cfg_data;
        REG_CENTER_Z: center_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Particle capture: the deltas are one bit wider than a position and never wrap.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mass_r <= in_mass;
      last_r <= in_last;
      d_r[0] <= D_W'(in_pos_x) - D_W'(center_r[0]);
      d_r[1] <= D_W'(in_pos_y) - D_W'(center_r[1]);
      d_r[2] <= D_W'(in_pos_z) - D_W'(center_r[2]);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_a)
      AXIS_X:  mul_a = md_r[0];
      AXIS_Y:  mul_a = md_r[1];
      default: mul_a = md_r[2];
    endcase
    if (cmd.mul_mass) begin
      mul_a = signed'({{(MD_W-MASS_BITS){1'b0}}, mass_r});
    end
    case (cmd.mul_b)
      AXIS_X:  mul_b = d_r[0];
      AXIS_Y:  mul_b = d_r[1];
      default: mul_b = d_r[2];
    endcase
  end

  assign prod = mul_a * mul_b;

  // The two squares that make up a diagonal term.
  always_comb begin
    case (cmd.sq_skip)
      AXIS_X: begin
        sq_a = sq_r[1];
        sq_b = sq_r[2];
      end
      AXIS_Y: begin
        sq_a = sq_r[0];
        sq_b = sq_r[2];
      end
      default: begin
        sq_a = sq_r[0];
        sq_b = sq_r[1];
      end
    endcase
    sq_sum = {sq_a[P_W-1], sq_a} + {sq_b[P_W-1], sq_b};
  end

  // Product registers and the shifted term register.
  always_ff @(posedge clk) begin
    case (cmd.mul_dst)
      MUL_TO_MD: begin
        case (cmd.mul_slot)
          AXIS_X:  md_r[0] <= prod[MD_W-1:0];
          AXIS_Y:  md_r[1] <= prod[MD_W-1:0];
          default: md_r[2] <= prod[MD_W-1:0];
        endcase
      end
      MUL_TO_SQ: begin
        case (cmd.mul_slot)
          AXIS_X:  sq_r[0] <= prod;
          AXIS_Y:  sq_r[1] <= prod;
          default: sq_r[2] <= prod;
        endcase
      end
      MUL_TO_TERM: begin
        term_r <= {prod[P_W-1], prod[P_W-1:PROD_SHIFT]};
      end
      default: ;
    endcase
    if (cmd.sq_sum_en) begin
      term_r <= sq_sum[P_W:PROD_SHIFT];
    end
  end

  // Saturating accumulate: diagonals add the term, cross sums subtract it.
  always_comb begin
    acc_idx  = cmd.acc_cross ? ({1'b0, cmd.acc_slot} + CROSS_BASE) : {1'b0, cmd.acc_slot};
    acc_ext  = S_W'(acc_r[acc_idx]);
    term_ext = S_W'(term_r);
    acc_sum  = cmd.acc_cross ? (acc_ext - term_ext) : (acc_ext + term_ext);
    acc_clip = 1'b0;
    acc_nxt  = acc_sum[ACC_BITS-1:0];
    if (acc_sum > ACC_HI) begin
      acc_nxt  = ACC_HI[ACC_BITS-1:0];
      acc_clip = 1'b1;
    end else if (acc_sum < ACC_LO) begin
      acc_nxt  = ACC_LO[ACC_BITS-1:0];
      acc_clip = 1'b1;
    end
  end

  // Accumulator file and sticky saturation flag, cleared when a set is emitted.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      for (int i = 0; i < ACC_COUNT; i++) begin
        acc_r[i] <= '0;
      end
      ovf_r <= 1'b0;
    end else if (cmd.acc_en) begin
      acc_r[acc_idx] <= acc_nxt;
      if (acc_clip) ovf_r <= 1'b1;
    end
  end

  // Output register: holds a finished tensor until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ixx_r <= acc_r[0][ACC_BITS-2:0];
      out_iyy_r <= acc_r[1][ACC_BITS-2:0];
      out_izz_r <= acc_r[2][ACC_BITS-2:0];
      out_ixy_r <= acc_r[3];
      out_ixz_r <= acc_r[4];
      out_iyz_r <= acc_r[5];
      out_sat_r <= ovf_r;
    end
  end

  assign status.item_last = last_r;
  assign status.out_full  = out_valid_r && !out_ready;

  assign out_valid     = out_valid_r;
  assign out_ixx       = out_ixx_r;
  assign out_iyy       = out_iyy_r;
  assign out_izz       = out_izz_r;
  assign out_ixy       = out_ixy_r;
  assign out_ixz       = out_ixz_r;
  assign out_iyz       = out_iyz_r;
  assign out_saturated = out_sat_r;

endmodule

// File: sv/inertia_tensor_accumulator_core.sv
// Top level of the inertia tensor accumulator: sequencer plus datapath.
// Depends on itacc_pkg, itacc_ctrl and itacc_dp.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    mass, pos_x, pos_y, pos_z, last
//   out      output     out_valid / out_ready  ixx, iyy, izz, ixy, ixz, iyz, saturated
//   cfg      input      cfg_we                 cfg_index, cfg_data (center x, y, z)
//
// Each particle is accepted in a capture step and then passes through thirteen steps around
// the single shared multiplier and the saturating accumulator before the next acceptance.
// A particle marked last adds an emit step, which waits while the output register is full.
// A finished tensor waits in the output register, so the next particle is taken
// while out_ready is low. Reset is synchronous and clears the sums, flag and centers.
module inertia_tensor_accumulator_core import itacc_pkg::*; #(
  parameter int unsigned POSITION_BITS = 20,
  parameter int unsigned MASS_BITS     = 18,
  parameter int unsigned ACC_BITS      = 56
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [CFG_INDEX_W-1:0]          cfg_index,
  input  logic [POSITION_BITS-1:0]        cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [MASS_BITS-1:0]            in_mass,
  input  logic signed [POSITION_BITS-1:0] in_pos_x,
  input  logic signed [POSITION_BITS-1:0] in_pos_y,
  input  logic signed [POSITION_BITS-1:0] in_pos_z,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ACC_BITS-2:0]             out_ixx,
  output logic [ACC_BITS-2:0]             out_iyy,
  output logic [ACC_BITS-2:0]             out_izz,
  output logic signed [ACC_BITS-1:0]      out_ixy,
  output logic signed [ACC_BITS-1:0]      out_ixz,
  output logic signed [ACC_BITS-1:0]      out_iyz,
  output logic                            out_saturated
);

  itacc_cmd_t    cmd;
  itacc_status_t status;

  // Step sequencer.
  itacc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  itacc_dp #(
    .POSITION_BITS (POSITION_BITS),
    .MASS_BITS     (MASS_BITS),
    .ACC_BITS      (ACC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mass       (in_mass),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ixx       (out_ixx),
    .out_iyy       (out_iyy),
    .out_izz       (out_izz),
    .out_ixy       (out_ixy),
    .out_ixz       (out_ixz),
    .out_iyz       (out_iyz),
    .out_saturated (out_saturated)
  );

endmodule
